// ===== src/bgkc_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, stage map, codes and types for the bgk collision stepper
// no dependencies; every module of the block imports this package

package bgkc_pkg;

  // population values, signed q4.28 at the default width
  localparam int VALUE_WIDTH = 32;

  // relaxation factors, unsigned q1.30
  localparam int OMEGA_W    = 31;
  localparam int OMEGA_FRAC = 30;

  // configuration port
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = OMEGA_W;

  // datapath widths, sized so that no intermediate ever wraps
  localparam int DIFF_W   = VALUE_WIDTH + 1;   // g - f
  localparam int BDF_W    = VALUE_WIDTH + 3;   // 4*s - sb
  localparam int MUL_IN_W = VALUE_WIDTH + 8;   // largest rk4 stage difference
  localparam int MUL_LO_W = MUL_IN_W / 2;
  localparam int MUL_HI_W = MUL_IN_W - MUL_LO_W;
  localparam int PP_LO_W  = MUL_LO_W + OMEGA_W;
  localparam int PP_HI_W  = MUL_HI_W + OMEGA_W + 1;
  localparam int PROD_W   = MUL_IN_W + OMEGA_W + 1;
  localparam int K_W      = VALUE_WIDTH + 9;   // collision terms k1..k4
  localparam int SUM_W    = VALUE_WIDTH + 10;
  localparam int X_W      = VALUE_WIDTH + 9;   // divide-by-three operand
  localparam int U_W      = X_W + 1;           // biased, unsigned operand
  localparam int R_W      = VALUE_WIDTH + 12;  // unclipped result

  // bias that makes the divide-by-three operand non-negative, divided by three
  localparam logic signed [R_W-1:0] Q_BIAS =
    {{(R_W - X_W){1'b0}}, 1'b1, {(X_W - 1){1'b0}}};

  // divide by three, a chunk of bits per stage
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STAGES = (U_W + DIV_CHUNK - 1) / DIV_CHUNK;

  // pipeline stage map
  localparam int ST_PREP   = 0;
  localparam int ST_K1_MUL = 1;                // also the before-term multiply
  localparam int ST_D2     = 3;
  localparam int ST_K2_MUL = 4;
  localparam int ST_D3     = 6;
  localparam int ST_K3_MUL = 7;
  localparam int ST_D4     = 9;
  localparam int ST_K4_MUL = 10;
  localparam int ST_SUM    = 12;
  localparam int ST_DIVIN  = 13;
  localparam int ST_DIV    = 14;
  localparam int ST_R      = ST_DIV + DIV_STAGES;
  localparam int ST_OUT    = ST_R + 1;
  localparam int PIPE_DEPTH = ST_OUT + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_EULER = 2'd0,
    MODE_AM3   = 2'd1,
    MODE_BDF2  = 2'd2,
    MODE_RK4   = 2'd3
  } stepper_mode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEPPER_MODE = 2'd0,
    REG_OMEGA_NOW    = 2'd1,
    REG_OMEGA_BEFORE = 2'd2
  } cfg_reg_e;

  // per-stage load enables and occupancy
  typedef struct packed {
    logic [PIPE_DEPTH-1:0] load;
    logic [PIPE_DEPTH-1:0] valid;
  } bgkc_pipe_t;

  // values that ride along the pipeline
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] s;
    logic signed [DIFF_W-1:0]      d0;
    logic signed [DIFF_W-1:0]      db;
    logic signed [BDF_W-1:0]       n;
    logic signed [MUL_IN_W-1:0]    diff;
    logic signed [K_W-1:0]         k1;
    logic signed [K_W-1:0]         cb;
    logic signed [K_W-1:0]         k2;
    logic signed [K_W-1:0]         k3;
    logic signed [SUM_W-1:0]       p1;
    logic signed [SUM_W-1:0]       p2;
    logic signed [SUM_W-1:0]       t;
    logic [U_W-1:0]                u;
    logic signed [R_W-1:0]         carry;
  } bgkc_side_t;

endpackage

// ===== src/bgkc_omega_mul.sv =====
`timescale 1ns / 1ps
// two-stage multiply of a signed difference by an unsigned q1.30 omega, floor >> 30
// depends on bgkc_pkg for widths

module bgkc_omega_mul (
  input  logic                                clk_i,
  input  logic [1:0]                          load_i,
  input  logic signed [bgkc_pkg::MUL_IN_W-1:0] operand_i,
  input  logic [bgkc_pkg::OMEGA_W-1:0]        omega_i,
  output logic signed [bgkc_pkg::K_W-1:0]     product_o
);
  import bgkc_pkg::*;

  logic [MUL_LO_W-1:0]        lo;
  logic signed [MUL_HI_W-1:0] hi;
  logic [PP_LO_W-1:0]         pp_lo_d, pp_lo_q;
  logic signed [PP_HI_W-1:0]  pp_hi_d, pp_hi_q;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [K_W-1:0]      product_q;

  // split the operand so that each partial product stays within 52 bits
  assign lo = operand_i[MUL_LO_W-1:0];
  assign hi = $signed(operand_i[MUL_IN_W-1:MUL_LO_W]);

  assign pp_lo_d = PP_LO_W'(lo) * PP_LO_W'(omega_i);
  assign pp_hi_d = PP_HI_W'(hi) * PP_HI_W'($signed({1'b0, omega_i}));

  assign prod_d = (PROD_W'(pp_hi_q) <<< MUL_LO_W) + $signed(PROD_W'(pp_lo_q));

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
    // arithmetic shift of the full product is the floor
    if (load_i[1]) begin
      product_q <= prod_d[OMEGA_FRAC +: K_W];
    end
  end

  assign product_o = product_q;

endmodule

// ===== src/bgkc_div3.sv =====
`timescale 1ns / 1ps
// pipelined unsigned divide by three, restoring, a chunk of bits per stage
// depends on bgkc_pkg for the operand width and stage count

module bgkc_div3 (
  input  logic                               clk_i,
  input  logic [bgkc_pkg::DIV_STAGES-1:0]    load_i,
  input  logic [bgkc_pkg::U_W-1:0]           dividend_i,
  output logic [bgkc_pkg::U_W-1:0]           quotient_o
);
  import bgkc_pkg::*;

  localparam logic [2:0] DIV_BASE = 3'd3;

  // upper two bits hold the running remainder, processed bits turn into quotient bits
  logic [U_W+1:0] stg_d [DIV_STAGES];
  logic [U_W+1:0] stg_q [DIV_STAGES];

  function automatic logic [U_W+1:0] div_chunk(input logic [U_W+1:0] acc_in,
                                               input int base);
    logic [U_W+1:0] acc;
    logic [2:0]     part;
    int             pos;
    acc = acc_in;
    for (int j = 0; j < DIV_CHUNK; j++) begin
      if (base + j < U_W) begin
        pos  = U_W - 1 - base - j;
        part = {acc[U_W+1:U_W], acc[pos]};
        if (part >= DIV_BASE) begin
          acc[U_W+1:U_W] = 2'(part - DIV_BASE);
          acc[pos]       = 1'b1;
        end else begin
          acc[U_W+1:U_W] = part[1:0];
          acc[pos]       = 1'b0;
        end
      end
    end
    return acc;
  endfunction

  always_comb begin
    stg_d[0] = div_chunk({2'b00, dividend_i}, 0);
    for (int g = 1; g < DIV_STAGES; g++) begin
      stg_d[g] = div_chunk(stg_q[g-1], g * DIV_CHUNK);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < DIV_STAGES; g++) begin
      if (load_i[g]) begin
        stg_q[g] <= stg_d[g];
      end
    end
  end

  assign quotient_o = stg_q[DIV_STAGES-1][U_W-1:0];

endmodule

// ===== src/bgkc_pipe_ctrl.sv =====
`timescale 1ns / 1ps
// stage occupancy and load enables with bubble collapse for the stepper pipeline
// depends on bgkc_pkg for the depth and the control struct

module bgkc_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_stall_i,
  output logic                 in_stall_o,
  output bgkc_pkg::bgkc_pipe_t pipe_o
);
  import bgkc_pkg::*;

  logic [PIPE_DEPTH-1:0] valid_d, valid_q;
  logic [PIPE_DEPTH-1:0] ready;

  // a stage may load if any stage from it to the end is empty, or the output drains
  always_comb begin
    logic [PIPE_DEPTH-1:0] mask;
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      mask     = {PIPE_DEPTH{1'b1}} << k;
      ready[k] = !out_stall_i || (|(~valid_q & mask));
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o   = !ready[0];
  assign pipe_o.load  = ready;
  assign pipe_o.valid = valid_q;

endmodule

// ===== src/bgk_collision_time_stepper.sv =====
`timescale 1ns / 1ps
// BGK collision for one lattice Boltzmann population per transfer, four time steppers
// depends on bgkc_pkg, bgkc_pipe_ctrl, bgkc_omega_mul and bgkc_div3

// Takes one population per clock (post-stream value and equilibrium for this step
// and the previous one) and returns the collided value in signed q4.28, clipped to
// the value range with saturated_flag_o set on a clip. Modes: forward Euler, AM3,
// BDF2 and RK4 with half-step stages; omega registers hold 1/tau in unsigned q1.30.
// Every mode runs through the same 22-stage pipeline (16 plus the divide stages), and a
// new item is taken every cycle while the input is not stalled. The length is set by
// the four chained omega multiplies of RK4, two stages each, and the pipelined divide
// by three used by BDF2 and RK4, eight quotient bits per stage.
// A stalled output only holds back the input once every stage is full. Configuration
// writes are always ready and must happen while the pipeline is empty.

module bgk_collision_time_stepper (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [bgkc_pkg::VALUE_WIDTH-1:0] streamed_now_i,
  input  logic signed [bgkc_pkg::VALUE_WIDTH-1:0] equilibrium_now_i,
  input  logic signed [bgkc_pkg::VALUE_WIDTH-1:0] streamed_before_i,
  input  logic signed [bgkc_pkg::VALUE_WIDTH-1:0] equilibrium_before_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [bgkc_pkg::VALUE_WIDTH-1:0] collided_o,
  output logic                                    saturated_flag_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [bgkc_pkg::CFG_INDEX_W-1:0]        cfg_index_i,
  input  logic [bgkc_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import bgkc_pkg::*;

  localparam logic signed [VALUE_WIDTH-1:0] COLL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] COLL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [OMEGA_W-1:0]            OMEGA_ONE = OMEGA_W'(1) << OMEGA_FRAC;

  stepper_mode_e        mode_q;
  logic [OMEGA_W-1:0]   omega_now_q, omega_before_q;

  bgkc_pipe_t           pipe;
  bgkc_side_t           side_d [ST_R+1];
  bgkc_side_t           side_q [ST_R+1];

  logic signed [K_W-1:0] k1, cb, k2, k3, k4;
  logic [U_W-1:0]        quot;

  logic                  is_rk, is_q, use_cb;

  logic signed [VALUE_WIDTH-1:0] collided_d, collided_q;
  logic                          flag_d, flag_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_EULER;
      omega_now_q    <= OMEGA_ONE;
      omega_before_q <= OMEGA_ONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEPPER_MODE: mode_q         <= stepper_mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_OMEGA_NOW:    omega_now_q    <= cfg_data_i;
        REG_OMEGA_BEFORE: omega_before_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign is_rk  = (mode_q == MODE_RK4);
  assign is_q   = (mode_q == MODE_BDF2) || (mode_q == MODE_RK4);
  assign use_cb = (mode_q == MODE_AM3) || (mode_q == MODE_BDF2);

  bgkc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .pipe_o      (pipe)
  );

  // k1 and the previous-step term share the first multiply slot
  bgkc_omega_mul u_mul_k1 (
    .clk_i     (clk_i),
    .load_i    (pipe.load[ST_K1_MUL +: 2]),
    .operand_i (MUL_IN_W'(side_q[ST_PREP].d0)),
    .omega_i   (omega_now_q),
    .product_o (k1)
  );

  bgkc_omega_mul u_mul_cb (
    .clk_i     (clk_i),
    .load_i    (pipe.load[ST_K1_MUL +: 2]),
    .operand_i (MUL_IN_W'(side_q[ST_PREP].db)),
    .omega_i   (omega_before_q),
    .product_o (cb)
  );

  bgkc_omega_mul u_mul_k2 (
    .clk_i     (clk_i),
    .load_i    (pipe.load[ST_K2_MUL +: 2]),
    .operand_i (side_q[ST_D2].diff),
    .omega_i   (omega_now_q),
    .product_o (k2)
  );

  bgkc_omega_mul u_mul_k3 (
    .clk_i     (clk_i),
    .load_i    (pipe.load[ST_K3_MUL +: 2]),
    .operand_i (side_q[ST_D3].diff),
    .omega_i   (omega_now_q),
    .product_o (k3)
  );

  bgkc_omega_mul u_mul_k4 (
    .clk_i     (clk_i),
    .load_i    (pipe.load[ST_K4_MUL +: 2]),
    .operand_i (side_q[ST_D4].diff),
    .omega_i   (omega_now_q),
    .product_o (k4)
  );

  bgkc_div3 u_div3 (
    .clk_i      (clk_i),
    .load_i     (pipe.load[ST_DIV +: DIV_STAGES]),
    .dividend_i (side_q[ST_DIVIN].u),
    .quotient_o (quot)
  );

  always_comb begin
    logic signed [SUM_W-1:0] rk_sum;
    logic signed [X_W-1:0]   x;

    for (int k = 1; k <= ST_R; k++) begin
      side_d[k] = side_q[k-1];
    end

    side_d[ST_PREP]    = '0;
    side_d[ST_PREP].s  = streamed_now_i;
    side_d[ST_PREP].d0 = DIFF_W'(equilibrium_now_i) - DIFF_W'(streamed_now_i);
    side_d[ST_PREP].db = DIFF_W'(equilibrium_before_i) - DIFF_W'(streamed_before_i);
    side_d[ST_PREP].n  = (BDF_W'(streamed_now_i) <<< 2) - BDF_W'(streamed_before_i);

    // half-step stages: the next difference is d0 - k/2, the last one d0 - k3
    side_d[ST_D2].k1   = k1;
    side_d[ST_D2].cb   = cb;
    side_d[ST_D2].diff = MUL_IN_W'(side_q[ST_D2-1].d0) - MUL_IN_W'(k1 >>> 1);

    side_d[ST_D3].k2   = k2;
    side_d[ST_D3].diff = MUL_IN_W'(side_q[ST_D3-1].d0) - MUL_IN_W'(k2 >>> 1);

    side_d[ST_D4].k3   = k3;
    side_d[ST_D4].diff = MUL_IN_W'(side_q[ST_D4-1].d0) - MUL_IN_W'(k3);

    side_d[ST_SUM].p1 = SUM_W'(side_q[ST_SUM-1].k1) + SUM_W'(k4);
    side_d[ST_SUM].p2 = SUM_W'(side_q[ST_SUM-1].k2) + SUM_W'(side_q[ST_SUM-1].k3);
    if (is_rk) begin
      side_d[ST_SUM].t = SUM_W'(side_q[ST_SUM-1].s);
    end else if (use_cb) begin
      side_d[ST_SUM].t = SUM_W'(side_q[ST_SUM-1].k1) - SUM_W'(side_q[ST_SUM-1].cb);
    end else begin
      side_d[ST_SUM].t = SUM_W'(side_q[ST_SUM-1].k1);
    end

    // floor(sum / 6) is floor(floor(sum / 2) / 3)
    rk_sum = side_q[ST_DIVIN-1].p1 + (side_q[ST_DIVIN-1].p2 <<< 1);
    if (is_rk) begin
      x = X_W'(rk_sum >>> 1);
    end else begin
      x = X_W'(side_q[ST_DIVIN-1].n);
    end
    // adding 3 * 2^(X_W-1) is a flip of the sign bit plus a new top bit
    side_d[ST_DIVIN].u = {1'b1, ~x[X_W-1], x[X_W-2:0]};
    if (is_q) begin
      side_d[ST_DIVIN].carry = R_W'(side_q[ST_DIVIN-1].t) - Q_BIAS;
    end else begin
      side_d[ST_DIVIN].carry = R_W'(side_q[ST_DIVIN-1].s) + R_W'(side_q[ST_DIVIN-1].t);
    end

    if (is_q) begin
      side_d[ST_R].carry = side_q[ST_R-1].carry + $signed(R_W'(quot));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= ST_R; k++) begin
      if (pipe.load[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // clip to the value range
  always_comb begin
    logic signed [R_W-1:0] r;
    logic                  over, under;
    r     = side_q[ST_R].carry;
    over  = !r[R_W-1] && (|r[R_W-2:VALUE_WIDTH-1]);
    under = r[R_W-1] && !(&r[R_W-2:VALUE_WIDTH-1]);
    if (over) begin
      collided_d = COLL_MAX;
    end else if (under) begin
      collided_d = COLL_MIN;
    end else begin
      collided_d = r[VALUE_WIDTH-1:0];
    end
    flag_d = over || under;
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[ST_OUT]) begin
      collided_q <= collided_d;
      flag_q     <= flag_d;
    end
  end

  assign out_valid_o      = pipe.valid[ST_OUT];
  assign collided_o       = collided_q;
  assign saturated_flag_o = flag_q;

  // a flagged result sits on one of the rails
  a_flag_on_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_flag_o) |-> (collided_o == COLL_MAX || collided_o == COLL_MIN))
    else $error("saturated result not on a rail");

  // an empty output stage never holds back the input
  a_no_stall_when_out_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // an input transfer always lands in the first stage
  a_transfer_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> pipe.valid[ST_PREP])
    else $error("accepted item lost at pipeline entry");

endmodule

// ===== test/bgk_collision_time_stepper_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for bgk_collision_time_stepper: directed corners, then random phases
// depends on bgkc_pkg and the bgk_collision_time_stepper rtl

module bgk_collision_time_stepper_tb;
  import bgkc_pkg::*;

  typedef logic signed [VALUE_WIDTH-1:0] population_t;

  typedef struct {
    population_t collided;
    logic        saturated;
  } collision_result_t;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [OMEGA_W-1:0] OMEGA_ONE = 31'h4000_0000;
  localparam logic [OMEGA_W-1:0] OMEGA_MAX = 31'h7FFF_FFFF;
  localparam population_t POP_MAX = 32'sh7FFF_FFFF;
  localparam population_t POP_MIN = 32'sh8000_0000;
  localparam population_t POP_ONE = 32'sh1000_0000;
  localparam longint LONG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LONG_MIN = -LONG_MAX - 1;
  localparam int DRAIN_CYCLES = 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  population_t streamed_now = '0;
  population_t equilibrium_now = '0;
  population_t streamed_before = '0;
  population_t equilibrium_before = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  population_t collided;
  logic saturated_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bgk_collision_time_stepper DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .streamed_now_i      (streamed_now),
    .equilibrium_now_i   (equilibrium_now),
    .streamed_before_i   (streamed_before),
    .equilibrium_before_i(equilibrium_before),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .collided_o          (collided),
    .saturated_flag_o    (saturated_flag),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  // shadow of the block's registers
  stepper_mode_e active_mode = MODE_EULER;
  logic [OMEGA_W-1:0] omega_now_q = OMEGA_ONE;
  logic [OMEGA_W-1:0] omega_before_q = OMEGA_ONE;

  collision_result_t pending_collisions[$];
  int mismatch_count = 0;
  bit input_gaps_on = 1'b1;
  bit output_stalls_on = 1'b1;
  int stall_left = 0;
  bit clip_hit;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("bgk_collision_time_stepper_tb NOT OK");
    $finish;
  end

  // ---------------- collision predictor, 64-bit saturating intermediates

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > LONG_MAX - b) begin
      clip_hit = 1'b1;
      return LONG_MAX;
    end
    if (b < 0 && a < LONG_MIN - b) begin
      clip_hit = 1'b1;
      return LONG_MIN;
    end
    return a + b;
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    if (b < 0 && a > LONG_MAX + b) begin
      clip_hit = 1'b1;
      return LONG_MAX;
    end
    if (b > 0 && a < LONG_MIN + b) begin
      clip_hit = 1'b1;
      return LONG_MIN;
    end
    return a - b;
  endfunction

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if (a < 0 && q * d != a) q -= 1;
    return q;
  endfunction

  // floor(a * w / 2^30) with w in unsigned q1.30
  function automatic longint scale_omega(longint a, longint w);
    longint whole, frac;
    if (w == 0) return 0;
    whole = floor_div(a, longint'(1) << OMEGA_FRAC);
    frac = a & ((longint'(1) << OMEGA_FRAC) - 1);
    if (whole > LONG_MAX / w) begin
      clip_hit = 1'b1;
      return LONG_MAX;
    end
    if (whole < LONG_MIN / w) begin
      clip_hit = 1'b1;
      return LONG_MIN;
    end
    return sat_add(whole * w, (frac * w) >> OMEGA_FRAC);
  endfunction

  function automatic longint relax(longint f, longint g, logic [OMEGA_W-1:0] w);
    return scale_omega(sat_sub(g, f), longint'(w));
  endfunction

  function automatic collision_result_t predict_collision(population_t s_in, population_t e_in,
                                                         population_t sb_in, population_t eb_in);
    longint s, e, sb, eb, r, k1, k2, k3, k4, sum, ceiling;
    collision_result_t res;
    s = s_in;
    e = e_in;
    sb = sb_in;
    eb = eb_in;
    clip_hit = 1'b0;
    case (active_mode)
      MODE_EULER: r = sat_add(s, relax(s, e, omega_now_q));
      MODE_AM3: begin
        r = sat_sub(sat_add(s, relax(s, e, omega_now_q)), relax(sb, eb, omega_before_q));
      end
      MODE_BDF2: begin
        r = floor_div(sat_sub(sat_add(sat_add(s, s), sat_add(s, s)), sb), 3);
        r = sat_sub(sat_add(r, relax(s, e, omega_now_q)), relax(sb, eb, omega_before_q));
      end
      default: begin
        k1 = relax(s, e, omega_now_q);
        k2 = relax(sat_add(s, floor_div(k1, 2)), e, omega_now_q);
        k3 = relax(sat_add(s, floor_div(k2, 2)), e, omega_now_q);
        k4 = relax(sat_add(s, k3), e, omega_now_q);
        sum = sat_add(sat_add(sat_add(k1, k4), sat_add(k2, k2)), sat_add(k3, k3));
        r = sat_add(s, floor_div(sum, 6));
      end
    endcase
    ceiling = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    if (r > ceiling) begin
      r = ceiling;
      clip_hit = 1'b1;
    end
    if (r < -ceiling - 1) begin
      r = -ceiling - 1;
      clip_hit = 1'b1;
    end
    res.collided = population_t'(r);
    res.saturated = clip_hit;
    return res;
  endfunction

  // ---------------- result checking

  always @(posedge clk_i) begin
    collision_result_t exp_res;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_collisions.size() == 0) begin
        $error("collided: no result expected, got %0d", collided);
        mismatch_count++;
      end else begin
        exp_res = pending_collisions.pop_front();
        if (collided !== exp_res.collided) begin
          $error("collided: expected %0d, got %0d", exp_res.collided, collided);
          mismatch_count++;
        end
        if (saturated_flag !== exp_res.saturated) begin
          $error("saturated_flag: expected %0b, got %0b", exp_res.saturated, saturated_flag);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------- idling

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    int n;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      n = output_stalls_on ? pick_gap() : 0;
      out_stall <= (n > 0);
      stall_left = (n > 0) ? n - 1 : 0;
    end
  end

  // ---------------- stimulus helpers

  task automatic send_population(input population_t s, input population_t e,
                                 input population_t sb, input population_t eb);
    int gap;
    streamed_now <= s;
    equilibrium_now <= e;
    streamed_before <= sb;
    equilibrium_before <= eb;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    pending_collisions.push_back(predict_collision(s, e, sb, eb));
    gap = input_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender holds off until every result is back, then lets the pipeline empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_collisions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_STEPPER_MODE: active_mode = stepper_mode_e'(data[MODE_W-1:0]);
      REG_OMEGA_NOW:    omega_now_q = data;
      REG_OMEGA_BEFORE: omega_before_q = data;
      default: ;
    endcase
  endtask

  // only while the pipeline is empty; upper mode bits carry junk on purpose
  task automatic configure_stepper(input stepper_mode_e mode, input logic [OMEGA_W-1:0] wn,
                                   input logic [OMEGA_W-1:0] wb, input bit touch_spare);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = CFG_DATA_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    write_register(REG_STEPPER_MODE, mode_word);
    write_register(REG_OMEGA_NOW, wn);
    if (touch_spare) write_register(REG_SPARE, CFG_DATA_W'($urandom));
    write_register(REG_OMEGA_BEFORE, wb);
    cfg_valid <= 1'b0;
  endtask

  function automatic population_t pick_population();
    case ($urandom_range(0, 9))
      0: return POP_MAX;
      1: return POP_MIN;
      2: return '0;
      3, 4, 5: return population_t'($urandom);
      default: return population_t'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
    endcase
  endfunction

  // mostly values near a smooth solution, sometimes anything at all
  function automatic population_t pick_near(population_t base);
    if ($urandom_range(0, 3) == 0) return pick_population();
    return base + population_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
  endfunction

  function automatic logic [OMEGA_W-1:0] pick_omega();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OMEGA_MAX;
      2: return OMEGA_ONE;
      3, 4: return OMEGA_W'($urandom);
      default: return OMEGA_W'($urandom_range(32'h0800_0000, 32'h7800_0000));
    endcase
  endfunction

  // ---------------- tests

  task automatic test_reset_config();
    send_population('0, '0, '0, '0);
    send_population(POP_MAX, POP_MIN, POP_MIN, POP_MAX);
    send_population(POP_MIN, POP_MAX, POP_MAX, POP_MIN);
    send_population(POP_ONE, POP_ONE >>> 1, -POP_ONE, 32'sh3000_0000);
    drain_pipeline();
  endtask

  task automatic test_mode_corners();
    stepper_mode_e mode;
    for (int m = 0; m < 4; m++) begin
      mode = stepper_mode_e'(m);
      configure_stepper(mode, OMEGA_MAX, OMEGA_MAX, 1'b0);
      send_population(POP_MAX, POP_MIN, POP_MIN, POP_MAX);
      send_population(POP_MIN, POP_MAX, POP_MAX, POP_MIN);
      // floor of a small negative quotient in the divide paths
      send_population(-32'sd1, '0, '0, -32'sd7);
      drain_pipeline();
      // zero omega leaves only the stepper's own combination of s and sb
      configure_stepper(mode, '0, '0, 1'b0);
      send_population(POP_MAX, POP_MIN, -POP_ONE, POP_MAX);
      drain_pipeline();
    end
  endtask

  task automatic test_register_masking();
    configure_stepper(MODE_RK4, OMEGA_ONE, OMEGA_MAX, 1'b1);
    send_population(POP_ONE, -POP_ONE, POP_MAX, POP_MIN);
    send_population(32'sh0123_4567, 32'sh7654_3210, 32'shF000_0001, 32'sh0FFF_FFFF);
    drain_pipeline();
  endtask

  task automatic test_random_phases(input int phases, input int items);
    population_t s;
    for (int p = 0; p < phases; p++) begin
      configure_stepper(stepper_mode_e'(p % 4), pick_omega(), pick_omega(),
                        $urandom_range(0, 3) == 0);
      input_gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
      output_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < items; i++) begin
        s = pick_population();
        send_population(s, pick_near(s), pick_near(s), pick_near(s));
      end
      drain_pipeline();
    end
    input_gaps_on = 1'b1;
    output_stalls_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_mode_corners();
    test_register_masking();
    test_random_phases(14, 100);
    if (mismatch_count == 0) begin
      $display("bgk_collision_time_stepper_tb OK");
    end else begin
      $display("bgk_collision_time_stepper_tb NOT OK");
    end
    $finish;
  end

endmodule
